// File: src/tfs_pkg.sv
// Shared types, codes and default sizes for the thread queue with search.
package tfs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;

    localparam logic [1:0] ACT_ENQUEUE = 2'd0;
    localparam logic [1:0] ACT_DEQUEUE = 2'd1;
    localparam logic [1:0] ACT_SEARCH  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] thread_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [3:0]  position;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIND = 2'b10
    } t_state;

endpackage

// File: src/tfs_cell.sv
// One queue cell: holds an identifier, shifts toward the front, compares with the key.
module tfs_cell #(
    parameter int ID_WIDTH = 16
) (
    input  logic                i_clk,
    input  logic                i_load,
    input  logic                i_shift,
    input  logic [ID_WIDTH-1:0] i_load_id,
    input  logic [ID_WIDTH-1:0] i_next_id,
    input  logic [ID_WIDTH-1:0] i_key,
    output logic [ID_WIDTH-1:0] o_id,
    output logic                o_hit
);

    logic [ID_WIDTH-1:0] r_id;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_id <= i_load_id;
        end else if (i_shift) begin
            r_id <= i_next_id;
        end
    end

    assign o_id  = r_id;
    assign o_hit = (r_id == i_key);

endmodule

// File: src/thread_fifo_with_search.sv
// Top level: shift queue of thread identifiers with first-match search.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------
//   in      | to block  | i_in_valid / o_in_stall    | i_in_data  (t_in_item)
//   out     | from block| o_out_valid / i_out_stall  | o_out_data (t_out_item)
//
// Enqueue, dequeue and no-op: result registered on acceptance,
// next transaction may enter on the following cycle.
// Search: the live cells' comparator hits are registered into r_match, then in
// S_FIND a first-match priority encoder over QUEUE_DEPTH bits forms the result,
// registered once the skid slot is free; input stalls until back in S_IDLE.
// Output has a one-entry skid slot; input stalls while it is occupied.
// Reset clears the count and handshake state; cell contents stay undefined.
module thread_fifo_with_search
    import tfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int ID_WIDTH    = ID_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W = $clog2(QUEUE_DEPTH);

    t_state                              r_state, n_state;
    logic [CNT_W-1:0]                    r_count, n_count;
    logic [QUEUE_DEPTH-1:0]              r_match;
    logic [ID_WIDTH-1:0]                 r_key;
    logic                                r_out_valid;
    t_out_item                           r_out;
    logic                                r_skid_valid;
    t_out_item                           r_skid;

    logic                                w_in_acc;
    logic                                w_out_take;
    logic [ID_WIDTH-1:0]                 w_key;
    logic                                w_full;
    logic                                w_empty;
    logic                                w_enq;
    logic                                w_deq;
    logic [QUEUE_DEPTH-1:0][ID_WIDTH-1:0] w_cell_id;
    logic [QUEUE_DEPTH-1:0]              w_cell_hit;
    logic [QUEUE_DEPTH-1:0]              w_live;
    logic [IDX_W-1:0]                    w_pos;
    logic                                w_put;
    t_out_item                           w_put_data;

    assign o_in_stall  = (r_state != S_IDLE) || r_skid_valid;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_take  = r_out_valid && !i_out_stall;
    assign w_key       = ID_WIDTH'(i_in_data.thread_id);
    assign w_full      = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_empty     = (r_count == '0);
    assign w_enq       = w_in_acc && (i_in_data.action == ACT_ENQUEUE) && !w_full;
    assign w_deq       = w_in_acc && (i_in_data.action == ACT_DEQUEUE) && !w_empty;

    // Cell k holds the entry k places behind the front.
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic [ID_WIDTH-1:0] w_next;
        if (k == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = w_cell_id[k];
        end else begin : g_mid
            assign w_next = w_cell_id[k+1];
        end

        tfs_cell #(
            .ID_WIDTH (ID_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_load    (w_enq && (r_count == CNT_W'(k))),
            .i_shift   (w_deq),
            .i_load_id (w_key),
            .i_next_id (w_next),
            .i_key     (w_key),
            .o_id      (w_cell_id[k]),
            .o_hit     (w_cell_hit[k])
        );

        assign w_live[k] = (CNT_W'(k) < r_count);
    end

    // First match from the front.
    always_comb begin
        w_pos = '0;
        for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                w_pos = IDX_W'(k);
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        w_put      = 1'b0;
        w_put_data = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_in_data.action == ACT_SEARCH) begin
                        n_state = S_FIND;
                    end else begin
                        w_put = 1'b1;
                        if (i_in_data.action == ACT_ENQUEUE) begin
                            if (w_full) begin
                                w_put_data.status = ST_FULL;
                            end else begin
                                n_count = r_count + CNT_W'(1);
                            end
                        end else if (i_in_data.action == ACT_DEQUEUE) begin
                            if (w_empty) begin
                                w_put_data.status = ST_EMPTY;
                            end else begin
                                n_count              = r_count - CNT_W'(1);
                                w_put_data.result_id = 16'(w_cell_id[0]);
                            end
                        end
                        w_put_data.occupancy = 5'(n_count);
                    end
                end
            end
            S_FIND: begin
                // Hold the search result until the skid slot frees up.
                if (!r_skid_valid) begin
                    n_state              = S_IDLE;
                    w_put                = 1'b1;
                    w_put_data.occupancy = 5'(r_count);
                    if (|r_match) begin
                        w_put_data.result_id = 16'(r_key);
                        w_put_data.position  = 4'(w_pos);
                    end else begin
                        w_put_data.status = ST_NOT_FOUND;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_in_acc && (i_in_data.action == ACT_SEARCH)) begin
                r_match <= w_cell_hit & w_live;
                r_key   <= w_key;
            end
            if (r_skid_valid) begin
                if (w_out_take) begin
                    r_out        <= r_skid;
                    r_skid_valid <= 1'b0;
                end
            end else if (w_put) begin
                if (!r_out_valid || w_out_take) begin
                    r_out       <= w_put_data;
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid       <= w_put_data;
                    r_skid_valid <= 1'b1;
                end
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a result while the output register is empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy count beyond queue depth");

    a_find_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIND) && !r_skid_valid |=> o_out_valid && (r_state == S_IDLE))
        else $error("search result not delivered to the output");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enq |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("enqueue did not advance the count");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_deq |=> r_count == $past(r_count) - CNT_W'(1))
        else $error("dequeue did not reduce the count");
`endif

endmodule
